[hdl/tws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

	localparam int POS_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int COL_W     = 10;
	localparam int DIST_W    = 16;
	localparam int TEX_H_W   = 11;
	localparam int PIX_ROW_W = 9;
	localparam int TEXEL_W   = 10;
	localparam int CNT_W     = $clog2(POS_W);

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic {
		UOP_DIV = 1'b0,
		UOP_MUL = 1'b1
	} unit_op_t;

	typedef struct packed {
		logic             start;
		unit_op_t         op;
		logic [CNT_W-1:0] top_bit;
	} unit_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDIV,
		ST_SETUP,
		ST_SDIV,
		ST_PMUL,
		ST_MOD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

[hdl/tws_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module tws_unit
	import tws_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire unit_cmd_t        cmd,
	input  wire logic [POS_W-1:0] oper_a,
	input  wire logic [POS_W-1:0] oper_b,
	output logic                  done,
	output logic [POS_W-1:0]      quotient,
	output logic [POS_W-1:0]      acc
);

	unit_op_t         op_q;
	logic [POS_W-1:0] a_q;
	logic [POS_W-1:0] b_q;
	logic [POS_W-1:0] acc_q;
	logic [POS_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic             is_div;
	logic             bit_in;
	logic [POS_W+1:0] x;
	logic [POS_W+1:0] y;
	logic [POS_W+1:0] sum;
	logic             qbit;
	logic [POS_W-1:0] acc_nx;

	// one shared adder: restoring divide step or shift-add multiply step
	always_comb begin
		is_div = (op_q == UOP_DIV);
		bit_in = a_q[cnt_q];
		if (is_div) begin
			x = {1'b0, acc_q, bit_in};
			y = ~{2'b0, b_q};
		end else begin
			x = {1'b0, acc_q, 1'b0};
			y = bit_in ? {2'b0, b_q} : '0;
		end
		sum  = x + y + {{(POS_W+1){1'b0}}, is_div};
		qbit = is_div & ~sum[POS_W+1];
		if (is_div && !qbit)
			acc_nx = x[POS_W-1:0];
		else
			acc_nx = sum[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.top_bit;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			a_q   <= oper_a;
			b_q   <= oper_b;
			acc_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			quo_q <= {quo_q[POS_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign acc      = acc_q;

endmodule

`default_nettype wire

[hdl/textured_wall_column_span.sv]
// Raycaster wall column span generator.
// Input channel (in_valid / in_stall): operation 0 starts a column with
// column, distance (unsigned Q8.8), texture_column and texture_height;
// operation 1 is a tick that asks for the next pixel request of the span.
// Output channel (out_valid / out_stall): one pixel request per tick while
// the span has rows left; a tick past the end of the span gives nothing.
// Start: two divisions and one multiplication on one shared adder, one bit
// per cycle; a zero wall height ends the start after the first division.
// in_stall stays high until the start work is done.
// Tick: the texture row is the remainder of the 16-bit integer texture position
// over texture_height from the same unit, one bit a cycle; a tick that emits
// holds in_stall until its request is loaded; an empty tick does not.
// The output register parts the channels: a waiting request does not hold
// off the next input, only the next request when the register is still full.
// Reset clears the span (no rows active) and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module textured_wall_column_span
	import tws_pkg::*;
#(
	parameter int SCREEN_HEIGHT = 512
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 operation,
	input  wire logic [COL_W-1:0]     column,
	input  wire logic [DIST_W-1:0]    distance,
	input  wire logic [COL_W-1:0]     texture_column,
	input  wire logic [TEX_H_W-1:0]   texture_height,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [COL_W-1:0]          pixel_column,
	output logic [PIX_ROW_W-1:0]      pixel_row,
	output logic [COL_W-1:0]          texel_column,
	output logic [TEXEL_W-1:0]        texel_row,
	output logic                      last_pixel
);

	localparam int HALF    = SCREEN_HEIGHT / 2;
	localparam int H_MAX   = SCREEN_HEIGHT * 256;
	localparam int H_W     = $clog2(H_MAX + 1);
	localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
	localparam int STEP_NB = TEX_H_W + FRAC_W;

	state_t state_q, state_nx;
	unit_cmd_t        cmd;
	logic [POS_W-1:0] oper_a, oper_b;
	logic             u_done;
	logic [POS_W-1:0] u_quo, u_acc;

	logic [ROW_W-1:0]   cur_row_q, end_row_q, row_q;
	logic [POS_W-1:0]   step_q, pos_q;
	logic [COL_W-1:0]   held_col_q, held_tcol_q;
	logic [TEX_H_W-1:0] held_th_q;
	logic [H_W-1:0]     h_q;
	logic [H_W-2:0]     offset_q;
	logic               last_q;
	logic [TEXEL_W-1:0] texel_q;

	logic               out_valid_q;
	logic [COL_W-1:0]   out_col_q, out_tcol_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [TEXEL_W-1:0] out_texel_q;
	logic               out_last_q;

	logic               accept;
	logic               span_left;
	logic               out_load;
	logic [DIST_W-1:0]  dist_eff;
	logic [H_W-2:0]     half_h;
	logic [H_W-1:0]     end_sum;
	logic [ROW_W-1:0]   start_v, end_v;
	logic [H_W-2:0]     off_v;

	tws_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.oper_a   (oper_a),
		.oper_b   (oper_b),
		.done     (u_done),
		.quotient (u_quo),
		.acc      (u_acc)
	);

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign span_left = (cur_row_q < end_row_q);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign dist_eff  = (distance == '0) ? DIST_W'(1) : distance;

	// span bounds from the wall height
	always_comb begin
		half_h  = h_q[H_W-1:1];
		end_sum = H_W'(half_h) + H_W'(HALF);
		if (half_h >= (H_W-1)'(HALF)) begin
			start_v = '0;
			off_v   = half_h - (H_W-1)'(HALF);
		end else begin
			start_v = ROW_W'((H_W-1)'(HALF) - half_h);
			off_v   = '0;
		end
		if (end_sum >= H_W'(SCREEN_HEIGHT))
			end_v = ROW_W'(SCREEN_HEIGHT - 1);
		else
			end_v = ROW_W'(end_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx    = state_q;
		cmd.start   = 1'b0;
		cmd.op      = UOP_DIV;
		cmd.top_bit = '0;
		oper_a      = '0;
		oper_b      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_START) begin
						cmd.start   = 1'b1;
						cmd.top_bit = CNT_W'(H_W - 1);
						oper_a      = POS_W'(H_MAX);
						oper_b      = POS_W'(dist_eff);
						state_nx    = ST_HDIV;
					end else if (span_left) begin
						cmd.start   = 1'b1;
						cmd.top_bit = CNT_W'(FRAC_W - 1);
						oper_a      = POS_W'(pos_q[POS_W-1:FRAC_W]);
						oper_b      = POS_W'(held_th_q);
						state_nx    = ST_MOD;
					end
				end
			end
			ST_HDIV: begin
				if (u_done)
					state_nx = ST_SETUP;
			end
			ST_SETUP: begin
				if (h_q != '0) begin
					cmd.start   = 1'b1;
					cmd.top_bit = CNT_W'(STEP_NB - 1);
					oper_a      = POS_W'({held_th_q, {FRAC_W{1'b0}}});
					oper_b      = POS_W'(h_q);
					state_nx    = ST_SDIV;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_SDIV: begin
				if (u_done) begin
					cmd.start   = 1'b1;
					cmd.op      = UOP_MUL;
					cmd.top_bit = CNT_W'(H_W - 2);
					oper_a      = POS_W'(offset_q);
					oper_b      = u_quo;
					state_nx    = ST_PMUL;
				end
			end
			ST_PMUL: begin
				if (u_done)
					state_nx = ST_IDLE;
			end
			ST_MOD: begin
				if (u_done)
					state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			end_row_q <= '0;
		end else if (state_q == ST_SETUP) begin
			cur_row_q <= start_v;
			end_row_q <= end_v;
		end else if (accept && operation == OP_TICK && span_left) begin
			cur_row_q <= cur_row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_START) begin
			held_col_q  <= column;
			held_tcol_q <= texture_column;
			held_th_q   <= texture_height;
		end
		if (accept && operation == OP_TICK && span_left) begin
			row_q  <= cur_row_q;
			last_q <= ((cur_row_q + ROW_W'(1)) == end_row_q);
			pos_q  <= pos_q + step_q;
		end
		if (state_q == ST_HDIV && u_done)
			h_q <= u_quo[H_W-1:0];
		if (state_q == ST_SETUP) begin
			offset_q <= off_v;
			if (h_q == '0) begin
				step_q <= '0;
				pos_q  <= '0;
			end
		end
		if (state_q == ST_SDIV && u_done)
			step_q <= u_quo;
		if (state_q == ST_PMUL && u_done)
			pos_q <= u_acc;
		if (state_q == ST_MOD && u_done)
			texel_q <= (held_th_q == '0) ? '0 : TEXEL_W'(u_acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q   <= held_col_q;
			out_tcol_q  <= held_tcol_q;
			out_row_q   <= row_q;
			out_texel_q <= texel_q;
			out_last_q  <= last_q;
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign pixel_column = out_col_q;
	assign pixel_row    = PIX_ROW_W'(out_row_q);
	assign texel_column = out_tcol_q;
	assign texel_row    = out_texel_q;
	assign last_pixel   = out_last_q;

endmodule

`default_nettype wire

[hdl/tws_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tws_checker
	import tws_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 operation,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [PIX_ROW_W-1:0] pixel_row,
	input wire logic [TEXEL_W-1:0]   texel_row,
	input wire logic                 last_pixel
);

	// an accepted column start is always followed by a busy period (in_stall high)
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_START |=> in_stall)
		else $error("start request taken without busy period");

	// texel remainder cannot finish in the cycle after a tick
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_TICK && !out_valid |=> !out_valid)
		else $error("pixel request appeared too early");

	// a fresh pixel request leaves the input side free
	a_rose_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled after pixel request loaded");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_row)
			&& $stable(texel_row) && $stable(last_pixel))
		else $error("stalled pixel request changed");

endmodule

bind textured_wall_column_span tws_checker u_tws_checker (.*);

`default_nettype wire
